// File: rtl/tcdq_pkg.sv
// Shared types, widths and codes for the two-class deque with key dedup.
`default_nettype none
package tcdq_pkg;

	localparam int KEY_W       = 37;
	localparam int AGE_W       = 8;
	localparam int ENTRY_W     = KEY_W + AGE_W + 1;
	localparam int HC_W        = 7;
	localparam int ST_W        = 3;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;
	localparam int DEPTH_DEF   = 64;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SERVE  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_SERVED    = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic             urgent;
		logic [AGE_W-1:0] age;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// File: rtl/two_class_deque_with_key_dedup_core.sv
// Top level of the two-class deque with duplicate-key rejection.
//
// Slave channel: one transaction per request. s_tuser selects insert (0) or
// serve (1); s_tdata carries key, age and urgent flag of an insert.
// Master channel: one transaction per request with the status code in
// m_tuser and the served entry plus the held count in m_tdata.
// An insert compares its key with every held entry, one store read a cycle;
// a serve reads the head once, and neither reads on an empty deque. The
// store's single read port sets this pace. One request is processed at a
// time; the next is accepted the cycle after a result is registered.
// The result register lets a new request be taken while the previous result
// waits; if the receiver still stalls when the next result is ready, the
// scan holds and s_tready stays low until m_tready frees the register.
// Reset empties the deque and drops any pending result; store contents are
// not cleared, as only held slots are ever read.
`default_nettype none
module two_class_deque_with_key_dedup_core #(
	parameter int QUEUE_DEPTH = tcdq_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// entry_key[36:0], entry_age[44:37], entry_urgent[45], zero pad
	input  wire logic [tcdq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// action[0]
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// served_key[36:0], served_age[44:37], served_urgent[45], held_count[52:46], zero pad
	output logic      [tcdq_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status[2:0]
	output logic      [tcdq_pkg::ST_W-1:0]        m_tuser
);

	tcdq_pkg::cmd_t  cmd;
	tcdq_pkg::stat_t stat;

	tcdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tcdq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one still in progress");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> stat.out_free && stat.scan_done)
		else $error("result committed over an untaken result or before scan end");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid && s_tready)
		else $error("committed result not presented");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.commit && s_tready)
		else $error("load outside idle");
`endif

endmodule
`default_nettype wire

// File: rtl/tcdq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tcdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/tcdq_ctrl.sv
// Controller state machine: accept, scan, commit.
`default_nettype none
module tcdq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire tcdq_pkg::stat_t stat,
	output tcdq_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done && stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/tcdq_dp.sv
// Datapath: ring pointers, key scan, entry store and output register.
`default_nettype none
module tcdq_dp #(
	parameter int QUEUE_DEPTH = tcdq_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tcdq_pkg::cmd_t                   cmd,
	output tcdq_pkg::stat_t                       stat,
	input  wire logic [tcdq_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                             s_tuser,
	input  wire logic                             m_tready,
	output logic                                  m_tvalid,
	output logic      [tcdq_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic      [tcdq_pkg::ST_W-1:0]        m_tuser
);

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W = tcdq_pkg::KEY_W;
	localparam int AGE_W = tcdq_pkg::AGE_W;
	localparam int HC_W  = tcdq_pkg::HC_W;
	localparam int PAD_W = tcdq_pkg::OUT_TDATA_W - (tcdq_pkg::ENTRY_W + HC_W);

	logic             act_q;
	tcdq_pkg::entry_t item_q;
	logic [AW-1:0]    head_q, slot_q;
	logic [CW-1:0]    cnt_q, left_q;
	logic             cmp_vld_q, dup_q, out_vld_q;

	tcdq_pkg::entry_t  rd_entry;
	logic [tcdq_pkg::ENTRY_W-1:0] rdata;
	logic              re, we;
	logic [AW-1:0]     waddr, head_d;
	logic [CW-1:0]     cnt_d;
	logic [AW:0]       tail_sum;
	tcdq_pkg::status_t st_d;
	tcdq_pkg::entry_t  served_d;

	tcdq_pkg::status_t st_q;
	tcdq_pkg::entry_t  served_q;
	logic [HC_W-1:0]   held_q;

	assign re       = (left_q != '0);
	assign rd_entry = tcdq_pkg::entry_t'(rdata);
	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(cnt_q);

	assign stat.scan_done = (left_q == '0) && !cmp_vld_q;
	assign stat.out_free  = !out_vld_q || m_tready;

	always_comb begin
		head_d   = head_q;
		cnt_d    = cnt_q;
		we       = 1'b0;
		waddr    = '0;
		served_d = '0;
		st_d     = tcdq_pkg::ST_EMPTY;
		if (act_q == tcdq_pkg::ACT_INSERT) begin
			priority if (dup_q) begin
				st_d = tcdq_pkg::ST_DUPLICATE;
			end else if (cnt_q == CW'(QUEUE_DEPTH)) begin
				st_d = tcdq_pkg::ST_FULL;
			end else begin
				st_d  = tcdq_pkg::ST_INSERTED;
				we    = 1'b1;
				cnt_d = cnt_q + CW'(1);
				if (item_q.urgent) begin
					head_d = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);
					waddr  = head_d;
				end else if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
					waddr = AW'(tail_sum - (AW+1)'(QUEUE_DEPTH));
				end else begin
					waddr = AW'(tail_sum);
				end
			end
		end else if (cnt_q != '0) begin
			st_d     = tcdq_pkg::ST_SERVED;
			served_d = rd_entry;
			cnt_d    = cnt_q - CW'(1);
			head_d   = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
		end
	end

	tcdq_ram #(
		.WIDTH(tcdq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we && cmd.commit),
		.waddr(waddr),
		.wdata(item_q),
		.re   (re),
		.raddr(slot_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q         <= s_tuser;
			item_q.key    <= s_tdata[KEY_W-1:0];
			item_q.age    <= s_tdata[KEY_W +: AGE_W];
			item_q.urgent <= s_tdata[KEY_W+AGE_W];
		end
		if (cmd.commit) begin
			st_q     <= st_d;
			served_q <= served_d;
			held_q   <= HC_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			cnt_q     <= '0;
			slot_q    <= '0;
			left_q    <= '0;
			cmp_vld_q <= 1'b0;
			dup_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			cmp_vld_q <= re;
			if (cmd.load) begin
				slot_q <= head_q;
				dup_q  <= 1'b0;
				if (s_tuser == tcdq_pkg::ACT_INSERT) begin
					left_q <= cnt_q;
				end else begin
					left_q <= (cnt_q != '0) ? CW'(1) : '0;
				end
			end else begin
				if (re) begin
					left_q <= left_q - CW'(1);
					slot_q <= (slot_q == AW'(QUEUE_DEPTH - 1)) ? '0 : slot_q + AW'(1);
				end
				if (cmp_vld_q && (act_q == tcdq_pkg::ACT_INSERT)
						&& (rd_entry.key == item_q.key)) begin
					dup_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				head_q    <= head_d;
				cnt_q     <= cnt_d;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = st_q;
	assign m_tdata  = {{PAD_W{1'b0}}, held_q, served_q.urgent, served_q.age, served_q.key};

endmodule
`default_nettype wire

// File: tb/sv/two_class_deque_with_key_dedup_core_chk.sv
// Checker for the two-class deque: watches both channels, predicts and compares results.
`default_nettype none
module two_class_deque_with_key_dedup_core_chk
	import tcdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic [ST_W-1:0]        m_tuser,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t          status;
		entry_t           served;
		logic [HC_W-1:0]  held;
	} result_t;

	entry_t  ring [QUEUE_DEPTH];
	int      head_slot;
	int      held_n;
	result_t pending_results [$];

	function automatic result_t apply_request(logic act, entry_t req);
		result_t r;
		bit      dup;
		int      slot;
		r   = '0;
		dup = 1'b0;
		if (act == ACT_INSERT) begin
			for (int i = 0; i < held_n; i++)
				if (ring[(head_slot + i) % QUEUE_DEPTH].key == req.key)
					dup = 1'b1;
			if (dup) begin
				r.status = ST_DUPLICATE;
			end else if (held_n >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (req.urgent) begin
					head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					slot      = head_slot;
				end else begin
					slot = (head_slot + held_n) % QUEUE_DEPTH;
				end
				ring[slot] = req;
				held_n++;
				r.status = ST_INSERTED;
			end
		end else if (held_n == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.served  = ring[head_slot];
			head_slot = (head_slot + 1) % QUEUE_DEPTH;
			held_n--;
			r.status  = ST_SERVED;
		end
		r.held = HC_W'(held_n);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			pending_results.delete();
			head_slot  = 0;
			held_n     = 0;
			pending    = 0;
			fail_count = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(apply_request(s_tuser, entry_t'(s_tdata[ENTRY_W-1:0])));
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.served = entry_t'(m_tdata[ENTRY_W-1:0]);
				got.held   = m_tdata[ENTRY_W +: HC_W];
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d key %h age %h urg %b held %0d",
							got.status, got.served.key, got.served.age, got.served.urgent,
							got.held);
				end else begin
					want = pending_results.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: status %0d/%0d key %h/%h age %h/%h",
								" urg %b/%b held %0d/%0d"},
								want.status, got.status, want.served.key, got.served.key,
								want.served.age, got.served.age, want.served.urgent,
								got.served.urgent, want.held, got.held);
					end
				end
			end
			pending = pending_results.size();
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/two_class_deque_with_key_dedup_core_tb.sv
// Testbench top for the two-class deque: stimulus, receiver stalls, watchdog and verdict.
`default_nettype none
module two_class_deque_with_key_dedup_core_tb;
	import tcdq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int N_RANDOM   = 1450;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_LEN   = 300;

	localparam logic [KEY_W-1:0] KEY_MAX  = '1;
	localparam logic [KEY_W-1:0] KEY_11DG = 37'd99999999999;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]        m_tuser;
	int                     fail_count;
	int                     pending;
	int                     items_sent = 0;
	bit                     draining   = 1'b0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	two_class_deque_with_key_dedup_core #(.QUEUE_DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	two_class_deque_with_key_dedup_core_chk #(.QUEUE_DEPTH(DEPTH)) i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic entry_t mk(logic [KEY_W-1:0] key, logic [AGE_W-1:0] age, logic urg);
		entry_t e;
		e.key    = key;
		e.age    = age;
		e.urgent = urg;
		return e;
	endfunction

	// small keys collide often, so duplicates show up once the deque is well filled
	function automatic logic [KEY_W-1:0] pick_key();
		logic [63:0] wide;
		int          r;
		r    = $urandom_range(0, 99);
		wide = {$urandom(), $urandom()};
		if (r < 40)
			return KEY_W'($urandom_range(0, 95));
		else if (r < 45)
			return '0;
		else if (r < 48)
			return KEY_MAX;
		else if (r < 50)
			return KEY_11DG;
		return wide[KEY_W-1:0];
	endfunction

	task automatic send(logic act, entry_t e);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_TDATA_W-ENTRY_W){1'b0}}, e};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver: changing stall patterns, plus two long hold-offs while the sender keeps going
	initial begin
		int mode;
		int left;
		int holds;
		left  = 0;
		mode  = 0;
		holds = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!draining && holds < 2 && items_sent >= (holds == 0 ? 300 : 900)) begin
				m_tready <= 1'b0;
				holds++;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 128);
			end
			if (draining)
				m_tready <= 1'b1;
			else
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= (left % 4 == 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			left--;
			@(posedge clk);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("two_class_deque_with_key_dedup_core test failed");
		$finish;
	end

	initial begin
		int     phase;
		int     phase_left;
		int     ins_pct;
		int     burst_left;
		logic   act;
		entry_t e;
		phase_left = 0;
		ins_pct    = 50;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send(ACT_SERVE, mk(KEY_MAX, 8'hFF, 1'b1));
		send(ACT_INSERT, mk('0, 8'h00, 1'b0));
		send(ACT_INSERT, mk(KEY_MAX, 8'hFF, 1'b1));
		send(ACT_INSERT, mk(KEY_11DG, 8'h5A, 1'b1));
		send(ACT_INSERT, mk('0, 8'hFF, 1'b1));
		pause(3);
		send(ACT_INSERT, mk(KEY_MAX, 8'h00, 1'b0));
		send(ACT_INSERT, mk(37'd1, 8'hA5, 1'b0));
		send(ACT_SERVE, mk('0, 8'h00, 1'b0));
		send(ACT_SERVE, mk(37'h0A5A5A5A5A, 8'h3C, 1'b0));
		pause(1);
		send(ACT_SERVE, mk(KEY_MAX, 8'hFF, 1'b1));
		send(ACT_SERVE, mk('0, 8'h00, 1'b0));
		send(ACT_SERVE, mk('0, 8'h00, 1'b0));
		send(ACT_INSERT, mk(37'd12345, 8'h81, 1'b1));
		send(ACT_INSERT, mk(37'h1555555555, 8'h7E, 1'b0));
		send(ACT_SERVE, mk('0, 8'h00, 1'b0));
		send(ACT_SERVE, mk('0, 8'h00, 1'b0));

		// random part: fill, drain and balanced phases
		for (int n = 0; n < N_RANDOM; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 2);
				case (phase)
					0: begin
						ins_pct    = 90;
						phase_left = $urandom_range(60, 200);
					end
					1: begin
						ins_pct    = 15;
						phase_left = $urandom_range(30, 120);
					end
					default: begin
						ins_pct    = 50;
						phase_left = $urandom_range(30, 120);
					end
				endcase
			end
			phase_left--;
			act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_SERVE;
			e   = mk(pick_key(), AGE_W'($urandom()), 1'($urandom()));
			send(act, e);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				case ($urandom_range(0, 9))
					0, 1: pause(0);
					2:    pause($urandom_range(20, 40));
					default: pause($urandom_range(1, 6));
				endcase
			end
			burst_left--;
		end

		s_tvalid <= 1'b0;
		draining = 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("two_class_deque_with_key_dedup_core test passed");
		else
			$display("two_class_deque_with_key_dedup_core test failed");
		$finish;
	end

endmodule
`default_nettype wire
